/* sv/wpm_pkg.sv */
`timescale 1ns / 1ps

package wpm_pkg;

    // Per-position kind codes; code three falls through to literal.
    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY_ONE = 2'd1,
        KIND_ANY_RUN = 2'd2,
        KIND_LIT_ALT = 2'd3
    } kind_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_CHARS_LOW  = 2'd0;
    localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
    localparam logic [1:0] REG_KINDS      = 2'd2;
    localparam logic [1:0] REG_LENGTH     = 2'd3;

    // Input tuser codes.
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    // Row-wide control shared by every cell.
    typedef struct packed {
        logic step;     // a transaction is taken this cycle
        logic restart;  // the transaction ends the text
        logic reclose;  // fold the current star closure into the stored bits
    } cell_ctrl_t;

endpackage

/* sv/wpm_cell.sv */
`timescale 1ns / 1ps

module wpm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  wpm_pkg::cell_ctrl_t ctrl,
    input  logic                enable,
    input  wpm_pkg::kind_t      kind,
    input  logic [7:0]          pattern_char,
    input  logic [7:0]          text_byte,
    input  logic                closed_in,
    output logic                closed_out,
    output logic                state_bit
);

    logic bit_reg;
    logic bit_next;
    logic take;
    logic is_star;

    assign is_star = enable && (kind == wpm_pkg::KIND_ANY_RUN);

    // The closed bit ripples to the right neighbor: a prefix that ends just
    // before a star also covers the prefix that includes the star.
    assign closed_out = bit_reg | (is_star & closed_in);
    assign state_bit  = bit_reg;

    always_comb
    begin
        unique case (kind)
            wpm_pkg::KIND_ANY_RUN: take = closed_in | closed_out;
            wpm_pkg::KIND_ANY_ONE: take = closed_in;
            default:               take = closed_in && (pattern_char == text_byte);
        endcase
    end

    always_comb
    begin
        priority if (ctrl.step)
        begin
            bit_next = ctrl.restart ? 1'b0 : (enable & take);
        end
        else if (ctrl.reclose)
        begin
            bit_next = closed_out;
        end
        else
        begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

endmodule

/* sv/wildcard_pattern_matcher.sv */
`timescale 1ns / 1ps
// An end-of-text transaction shows its result on the master side in the cycle after it is accepted.
// Throughput: one transaction per cycle unless a result waits; the prefix vector updates in
// one pass through the row of cells, which carries the star closure from cell to cell.
// Text-byte transactions produce no result, but while a result waits unaccepted the slave
// side holds off every transaction until the master side takes it.
// Reset clears the pattern registers and leaves only the empty prefix active.

module wildcard_pattern_matcher #(
    parameter int PATTERN_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] matched, [7:1] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int IDX_W = $clog2(PATTERN_LEN + 1);

    logic [63:0] chars_low_reg;
    logic [63:0] chars_high_reg;
    logic [31:0] kinds_reg;
    logic [4:0]  length_reg;
    logic        dirty_reg;
    logic        dirty_next;
    logic        head_reg;
    logic        head_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_matched_reg;

    logic [IDX_W-1:0]       used_len;
    logic [PATTERN_LEN:0]   closed_vec;
    logic [PATTERN_LEN:0]   state_vec;
    logic                   accept;
    wpm_pkg::cell_ctrl_t    ctrl;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign used_len = (length_reg > 5'(PATTERN_LEN)) ? IDX_W'(PATTERN_LEN)
                                                     : length_reg[IDX_W-1:0];

    // The stored vector is closed under the pattern in force when it was
    // written. Before the first pattern change after a transaction, that
    // closure is folded in so a later pattern closes on top of it.
    assign ctrl.step    = accept;
    assign ctrl.restart = (s_axis_tuser == wpm_pkg::ACTION_END);
    assign ctrl.reclose = cfg_we && dirty_reg;

    assign closed_vec[0] = head_reg;
    assign state_vec[0]  = head_reg;

    genvar i;
    generate
        for (i = 0; i < PATTERN_LEN; i++)
        begin : g_cell
            logic [7:0] pchar;
            if (i < 8)
            begin : g_low
                assign pchar = chars_low_reg[8*i +: 8];
            end
            else
            begin : g_high
                assign pchar = chars_high_reg[8*(i-8) +: 8];
            end

            wpm_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .enable       (IDX_W'(i) < used_len),
                .kind         (wpm_pkg::kind_t'(kinds_reg[2*i +: 2])),
                .pattern_char (pchar),
                .text_byte    (s_axis_tdata),
                .closed_in    (closed_vec[i]),
                .closed_out   (closed_vec[i+1]),
                .state_bit    (state_vec[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        head_next      = head_reg;
        dirty_next     = dirty_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (accept)
        begin
            head_next  = ctrl.restart;
            dirty_next = 1'b1;
            if (ctrl.restart)
            begin
                out_valid_next = 1'b1;
            end
        end
        else if (ctrl.reclose)
        begin
            dirty_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            kinds_reg      <= '0;
            length_reg     <= '0;
            dirty_reg      <= 1'b1;
            head_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wpm_pkg::REG_CHARS_LOW:  chars_low_reg  <= cfg_wdata;
                    wpm_pkg::REG_CHARS_HIGH: chars_high_reg <= cfg_wdata;
                    wpm_pkg::REG_KINDS:      kinds_reg      <= cfg_wdata[31:0];
                    wpm_pkg::REG_LENGTH:     length_reg     <= cfg_wdata[4:0];
                    default:                 length_reg     <= length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ctrl.restart)
        begin
            out_matched_reg <= closed_vec[used_len];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_matched_reg};

`ifndef SYNTHESIS
    a_byte_clears_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == wpm_pkg::ACTION_BYTE) |=> (state_vec[0] == 1'b0))
        else $error("empty prefix still active after a text byte");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == wpm_pkg::ACTION_END)
            |=> (state_vec == (PATTERN_LEN+1)'(1)))
        else $error("prefix vector not restarted after end of text");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == wpm_pkg::ACTION_END) |=> m_axis_tvalid)
        else $error("end of text produced no result");

    a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == wpm_pkg::ACTION_BYTE && !m_axis_tvalid)
            |=> !m_axis_tvalid)
        else $error("result appeared for a text byte");
`endif

endmodule
